// File: rtl/pspl_pkg.sv
`default_nettype none

package pspl_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int ADDR_SLOTS   = 16;
   localparam int CH_W         = $clog2(NUM_CHANNELS);
   localparam int SLOT_W       = $clog2(ADDR_SLOTS);

   // item kinds
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // bus register offsets
   localparam logic [1:0] REG_CMD     = 2'd0;
   localparam logic [1:0] REG_ADDR_LO = 2'd1;
   localparam logic [1:0] REG_ADDR_HI = 2'd2;
   localparam logic [1:0] REG_READY   = 2'd3;

   // effect codes
   localparam logic [1:0] EFF_MUTE  = 2'd0;
   localparam logic [1:0] EFF_SEVEN = 2'd1;
   localparam logic [1:0] EFF_TWO   = 2'd2;
   localparam logic [1:0] EFF_FULL  = 2'd3;

   // x/10 as (x * 205) >> 11, exact below 1029
   localparam logic [7:0] RECIP_TEN   = 8'd205;
   localparam int         RECIP_SHIFT = 11;

   typedef struct packed {
      logic [15:0] a;
      logic [7:0]  b;
      logic [15:0] c;
   } mac_op_type;

   localparam int MAC_W = 24;

endpackage

`default_nettype wire

// File: rtl/pspl_if.sv
`default_nettype none

interface pspl_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [1:0] reg_offset;
   logic [7:0] write_data;
   logic [1:0] channel;
   logic [7:0] rom_data;

   modport source (output valid, operation, reg_offset, write_data, channel, rom_data,
                   input ready);
   modport sink   (input valid, operation, reg_offset, write_data, channel, rom_data,
                   output ready);
endinterface

interface pspl_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [9:0] sample_value;
   logic [15:0]       fetch_address;
   logic              channel_active;

   modport source (output valid, sample_value, fetch_address, channel_active,
                   input ready);
   modport sink   (input valid, sample_value, fetch_address, channel_active,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/pspl_ram.sv
`default_nettype none

module pspl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/pspl_mac.sv
`default_nettype none

module pspl_mac
   import pspl_pkg::*;
(
   input  wire logic             clock,
   input  wire mac_op_type       op,
   output logic      [MAC_W-1:0] result_ff
);

   logic [MAC_W-1:0] result_in;

   // a * b + c, registered
   assign result_in = (MAC_W'(op.a) * MAC_W'(op.b)) + MAC_W'(op.c);

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

endmodule

`default_nettype wire

// File: rtl/percussion_sample_player.sv
// a play command adds a load step before the result
// a tick on a playing channel runs divide, volume, position, end and compare steps
// throughput: one item at a time; shared multiply-add runs five passes per live tick
// a finished result waits in the output register; the next item is taken meanwhile
// reset: synchronous, active high; clears all channels to idle, selected slot and ready flag
`default_nettype none

module percussion_sample_player
   import pspl_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   pspl_req_if.sink   req_ch,
   pspl_rsp_if.source rsp_ch
);

   // sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DECODE = 4'd1;
   localparam logic [3:0] ST_LOAD   = 4'd2;
   localparam logic [3:0] ST_DIV    = 4'd3;
   localparam logic [3:0] ST_VOL    = 4'd4;
   localparam logic [3:0] ST_POS    = 4'd5;
   localparam logic [3:0] ST_END    = 4'd6;
   localparam logic [3:0] ST_CMP    = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   logic [3:0] state_ff, state_in;

   // latched item
   logic            op_ff;
   logic [1:0]      off_ff;
   logic [7:0]      data_ff;
   logic [CH_W-1:0] ch_ff;
   logic [7:0]      rom_ff;

   // device state
   logic [SLOT_W-1:0] selected_ff;
   logic              ready_ff;
   logic [15:0]       pos_ff     [NUM_CHANNELS];
   logic              playing_ff [NUM_CHANNELS];
   logic [2:0]        pslot_ff   [NUM_CHANNELS];
   logic [1:0]        vol_ff     [NUM_CHANNELS];
   logic [1:0]        eff_ff     [NUM_CHANNELS];

   // working registers
   logic [15:0] end_base_ff;
   logic [9:0]  mag_ff;

   // output register
   logic              rsp_valid_ff;
   logic signed [9:0] rsp_sample_ff;
   logic [15:0]       rsp_addr_ff;
   logic              rsp_active_ff;

   // slot address store, split by byte so each half is written on its own
   logic              lo_wr, hi_wr, ram_rd;
   logic [SLOT_W-1:0] ram_rd_addr;
   logic [7:0]        lo_rd, hi_rd;

   // shared multiply-add
   mac_op_type       mac_op;
   logic [MAC_W-1:0] mac_res;

   logic [7:0]        rom_mag;
   logic [7:0]        eff_gain;
   logic [7:0]        scaled;
   logic              tick_live;
   logic              play_cmd;
   logic [CH_W-1:0]   play_ch;
   logic              out_free;
   logic [SLOT_W-1:0] next_slot;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // magnitude of the signed rom byte, 0x80 gives 128
   assign rom_mag   = rom_ff[7] ? (~rom_ff + 8'd1) : rom_ff;
   assign tick_live = ready_ff && playing_ff[ch_ff];
   assign play_cmd  = (data_ff[7:6] != EFF_MUTE) && !data_ff[5];
   assign play_ch   = data_ff[4:3];
   assign next_slot = SLOT_W'({1'b0, pslot_ff[ch_ff]}) + SLOT_W'(1);

   // numerator for the divide by ten: 7 or 4 times the magnitude; 1 for full, 0 for mute
   always_comb begin
      case (eff_ff[ch_ff])
         EFF_SEVEN: eff_gain = 8'd7;
         EFF_TWO:   eff_gain = 8'd4;
         EFF_FULL:  eff_gain = 8'd1;
         default:   eff_gain = 8'd0;
      endcase
   end

   // full effect bypasses the reciprocal
   assign scaled = (eff_ff[ch_ff] == EFF_FULL) ? rom_mag
                                              : mac_res[RECIP_SHIFT +: 8];

   // ram control
   always_comb begin
      lo_wr       = 1'b0;
      hi_wr       = 1'b0;
      ram_rd      = 1'b0;
      ram_rd_addr = next_slot;
      if (state_ff == ST_DECODE) begin
         if (op_ff == OP_WRITE) begin
            lo_wr       = (off_ff == REG_ADDR_LO);
            hi_wr       = (off_ff == REG_ADDR_HI);
            ram_rd      = (off_ff == REG_CMD) && play_cmd;
            ram_rd_addr = data_ff[5:2];
         end else begin
            ram_rd = tick_live;
         end
      end
   end

   pspl_ram #(.WIDTH(8), .DEPTH(ADDR_SLOTS)) u_addr_lo (
      .clock      (clock),
      .wr_en      (lo_wr),
      .wr_addr    (selected_ff),
      .wr_data    (data_ff),
      .rd_en      (ram_rd),
      .rd_addr    (ram_rd_addr),
      .rd_data_ff (lo_rd)
   );

   pspl_ram #(.WIDTH(8), .DEPTH(ADDR_SLOTS)) u_addr_hi (
      .clock      (clock),
      .wr_en      (hi_wr),
      .wr_addr    (selected_ff),
      .wr_data    (data_ff),
      .rd_en      (ram_rd),
      .rd_addr    (ram_rd_addr),
      .rd_data_ff (hi_rd)
   );

   // operand select for each pass of the shared unit
   always_comb begin
      mac_op = '0;
      unique case (state_ff)
         ST_DECODE: begin
            mac_op.a = {8'd0, rom_mag};
            mac_op.b = eff_gain;
         end
         ST_DIV: begin
            mac_op.a = mac_res[15:0];
            mac_op.b = RECIP_TEN;
         end
         ST_VOL: begin
            mac_op.a = {8'd0, scaled};
            mac_op.b = 8'({1'b0, vol_ff[ch_ff]} + 3'd1);
         end
         ST_POS: begin
            // position plus one
            mac_op.a = pos_ff[ch_ff];
            mac_op.b = 8'd1;
            mac_op.c = 16'd1;
         end
         ST_END: begin
            // next slot start minus one, wrapping
            mac_op.a = end_base_ff;
            mac_op.b = 8'd1;
            mac_op.c = 16'hFFFF;
         end
         default: mac_op = '0;
      endcase
   end

   pspl_mac u_mac (
      .clock     (clock),
      .op        (mac_op),
      .result_ff (mac_res)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_ch.valid) state_in = ST_DECODE;
         ST_DECODE: begin
            if (op_ff == OP_WRITE) begin
               state_in = ((off_ff == REG_CMD) && play_cmd) ? ST_LOAD : ST_DONE;
            end else begin
               state_in = tick_live ? ST_DIV : ST_DONE;
            end
         end
         ST_LOAD:   state_in = ST_DONE;
         ST_DIV:    state_in = ST_VOL;
         ST_VOL:    state_in = ST_POS;
         ST_POS:    state_in = ST_END;
         ST_END:    state_in = ST_CMP;
         ST_CMP:    state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         selected_ff <= '0;
         ready_ff    <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            playing_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DECODE && op_ff == OP_WRITE) begin
            if (off_ff == REG_CMD) selected_ff <= data_ff[5:2];
            if (off_ff == REG_READY) ready_ff <= 1'b1;
         end
         if (state_ff == ST_LOAD) begin
            playing_ff[play_ch] <= 1'b1;
         end
         // stop once the advanced position reaches the end mark
         if (state_ff == ST_CMP && pos_ff[ch_ff] >= mac_res[15:0]) begin
            playing_ff[ch_ff] <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_ch.valid) begin
         op_ff   <= req_ch.operation;
         off_ff  <= req_ch.reg_offset;
         data_ff <= req_ch.write_data;
         ch_ff   <= req_ch.channel;
         rom_ff  <= req_ch.rom_data;
      end
      if (state_ff == ST_DECODE) mag_ff <= '0;
      if (state_ff == ST_LOAD) begin
         pos_ff[play_ch]   <= {hi_rd, lo_rd};
         pslot_ff[play_ch] <= data_ff[4:2];
         vol_ff[play_ch]   <= data_ff[1:0];
         eff_ff[play_ch]   <= data_ff[7:6];
      end
      if (state_ff == ST_DIV) end_base_ff <= {hi_rd, lo_rd};
      if (state_ff == ST_POS) mag_ff <= mac_res[9:0];
      if (state_ff == ST_END) pos_ff[ch_ff] <= mac_res[15:0];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_sample_ff <= rom_ff[7] ? -$signed(mag_ff) : $signed(mag_ff);
         rsp_addr_ff   <= pos_ff[ch_ff];
         rsp_active_ff <= playing_ff[ch_ff];
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.sample_value   = rsp_sample_ff;
   assign rsp_ch.fetch_address  = rsp_addr_ff;
   assign rsp_ch.channel_active = rsp_active_ff;

   // a bus write never produces a sample
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && op_ff == OP_WRITE) |-> (mag_ff == '0))
      else $error("bus write left a nonzero sample");

   // the ready flag only ever sets
   a_ready_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(ready_ff))
      else $error("device ready flag cleared");

   // scaled magnitude stays within volume times full scale
   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (mag_ff <= 10'd512))
      else $error("sample magnitude out of range");

   // a channel load follows a decoded item
   a_load_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> ($past(state_ff) == ST_DECODE))
      else $error("channel load out of sequence");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none

module tb_top
   import pspl_pkg::*;
();

   // command field value that only selects a slot, no playback
   localparam logic [1:0] CMD_STORE = 2'd0;

   localparam int ITEM_TARGET   = 1200;
   localparam int IDLE_LIMIT    = 1000;  // cycles with no handshake on either side
   localparam int DRAIN_CYCLES  = 16;
   localparam int DIRECTED_ROWS = 25;
   localparam int SETUP_SLOTS   = 9;     // slots 0..8 are the only ones ever read back

   typedef struct packed {
      logic       operation;
      logic [1:0] reg_offset;
      logic [7:0] write_data;
      logic [1:0] channel;
      logic [7:0] rom_data;
   } drum_item_type;

   typedef struct packed {
      logic signed [9:0] sample_value;
      logic [15:0]       fetch_address;
      logic              channel_active;
      logic              addr_known;     // position of that channel has been loaded
   } drum_result_type;

   typedef struct packed {
      drum_item_type     item;
      logic              typed;          // expected result below is used as written
      logic signed [9:0] sample_value;
      logic [15:0]       fetch_address;
      logic              channel_active;
   } directed_row_type;

   // slot start table loaded right after reset
   //   slot 0..1 : short sample, stops after three ticks
   //   slot 2..3 : starts at 0xffff, position wraps through zero
   //   slot 4..5 : next slot start of zero, end address becomes 0xffff
   //   slot 6..7 : start already past the end, stops on the first tick
   localparam logic [15:0] INIT_SLOT_START [SETUP_SLOTS] = '{
      16'h0000, 16'h0004, 16'hFFFF, 16'h0003, 16'h0100,
      16'h0000, 16'h0200, 16'h0010, 16'h0210
   };

   logic clock;
   logic reset;

   pspl_req_if req_if ();
   pspl_rsp_if rsp_if ();

   percussion_sample_player dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // ------------------------------------------------------------------
   // player model state
   // ------------------------------------------------------------------
   logic [15:0] slot_start [ADDR_SLOTS];
   logic [3:0]  sel_slot;
   logic        player_ready;
   logic [15:0] chan_pos       [NUM_CHANNELS];
   logic        chan_pos_known [NUM_CHANNELS];
   logic        chan_playing   [NUM_CHANNELS];
   logic [2:0]  chan_slot      [NUM_CHANNELS];
   logic [1:0]  chan_vol       [NUM_CHANNELS];
   logic [1:0]  chan_eff       [NUM_CHANNELS];

   drum_result_type expected_samples [$];
   drum_result_type exp_res;

   int items_sent;
   int ticks_sent;
   int results_checked;
   int channel_stops;
   int mismatch_count;
   int idle_cycles;
   int rx_cycle;
   int burst_left;

   // ------------------------------------------------------------------
   // clock
   // ------------------------------------------------------------------
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // predictor: one item in, one result out, model state advanced
   // ------------------------------------------------------------------
   task automatic predict_player_step(input drum_item_type it, output drum_result_type res);
      logic [2:0]  s;
      logic [1:0]  c;
      logic [3:0]  nxt_slot;
      logic [15:0] end_addr;
      int          raw;
      int          mag;
      int          scaled;
      int          level;
      c     = it.channel;
      level = 0;
      if (it.operation == OP_WRITE) begin
         case (it.reg_offset)
            REG_CMD: begin
               sel_slot = it.write_data[5:2];
               // play commands only reach channels for slots 0..7
               if (it.write_data[7:6] != CMD_STORE && sel_slot < 4'd8) begin
                  s = sel_slot[2:0];
                  chan_pos[s[2:1]]       = slot_start[s];
                  chan_pos_known[s[2:1]] = 1'b1;
                  chan_playing[s[2:1]]   = 1'b1;
                  chan_slot[s[2:1]]      = s;
                  chan_vol[s[2:1]]       = it.write_data[1:0];
                  chan_eff[s[2:1]]       = it.write_data[7:6];
               end
            end
            REG_ADDR_LO: slot_start[sel_slot][7:0]  = it.write_data;
            REG_ADDR_HI: slot_start[sel_slot][15:8] = it.write_data;
            default:     player_ready = 1'b1;
         endcase
      end else if (player_ready && chan_playing[c]) begin
         nxt_slot = {1'b0, chan_slot[c]} + 4'd1;
         end_addr = slot_start[nxt_slot] - 16'd1;
         raw      = int'($signed(it.rom_data));
         mag      = (raw < 0) ? -raw : raw;
         case (chan_eff[c])
            EFF_SEVEN: scaled = (mag * 7) / 10;
            EFF_TWO:   scaled = (mag * 2) / 5;
            EFF_FULL:  scaled = mag;
            default:   scaled = 0;
         endcase
         if (raw < 0) scaled = -scaled;
         level       = scaled * (int'(chan_vol[c]) + 1);
         chan_pos[c] = chan_pos[c] + 16'd1;
         if (chan_pos[c] >= end_addr) begin
            chan_playing[c] = 1'b0;
            channel_stops++;
         end
      end
      res.sample_value   = level[9:0];
      res.fetch_address  = chan_pos[c];
      res.channel_active = chan_playing[c];
      res.addr_known     = chan_pos_known[c];
   endtask

   // ------------------------------------------------------------------
   // request driver: bursts of items separated by random gaps
   // ------------------------------------------------------------------
   task automatic send_item(input drum_item_type it, input bit typed,
                            input drum_result_type typed_res);
      int              gap;
      drum_result_type res;
      if (burst_left == 0) begin
         // every third stretch of 150 items runs back to back
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if ((items_sent / 150) % 3 == 2) gap = 0;
         if (gap != 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_if.valid      = 1'b1;
      req_if.operation  = it.operation;
      req_if.reg_offset = it.reg_offset;
      req_if.write_data = it.write_data;
      req_if.channel    = it.channel;
      req_if.rom_data   = it.rom_data;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_player_step(it, res);
      if (typed) begin
         res.sample_value   = typed_res.sample_value;
         res.fetch_address  = typed_res.fetch_address;
         res.channel_active = typed_res.channel_active;
      end
      expected_samples.push_back(res);
      items_sent++;
      if (it.operation == OP_TICK) ticks_sent++;
      @(negedge clock);
   endtask

   task automatic send_write(input logic [1:0] off, input logic [7:0] data, input logic [1:0] ch);
      send_item('{OP_WRITE, off, data, ch, 8'h00}, 1'b0, '0);
   endtask

   task automatic send_tick(input logic [1:0] ch, input logic [7:0] rom);
      send_item('{OP_TICK, REG_CMD, 8'h00, ch, rom}, 1'b0, '0);
   endtask

   // mostly a compact ascending layout so samples are short, now and then anything
   function automatic logic [15:0] pick_slot_start(input logic [3:0] slot);
      int k;
      k = $urandom_range(0, 9);
      if (k < 7) return 16'(int'(slot) * 16 + $urandom_range(0, 15));
      if (k < 9) return 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 2))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'hFFFE;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // directed items, typed expectations where they are obvious
   // ------------------------------------------------------------------
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // tick before any ready write and before channel 0 was loaded
      '{'{OP_TICK,  REG_CMD,     8'h00, 2'd0, 8'h80}, 1'b0, 10'd0, 16'h0000, 1'b0},
      // start slot 0 on channel 0, full level, volume 3
      '{'{OP_WRITE, REG_CMD, {EFF_FULL, 4'd0, 2'd3}, 2'd0, 8'h00},
        1'b1, 10'd0, 16'h0000, 1'b1},
      // still not ready: state untouched
      '{'{OP_TICK,  REG_CMD,     8'h00, 2'd0, 8'h80}, 1'b1, 10'd0, 16'h0000, 1'b1},
      '{'{OP_WRITE, REG_CMD, {EFF_SEVEN, 4'd2, 2'd0}, 2'd1, 8'h00},
        1'b1, 10'd0, 16'hFFFF, 1'b1},
      '{'{OP_WRITE, REG_CMD, {EFF_TWO, 4'd4, 2'd1}, 2'd2, 8'h00},
        1'b1, 10'd0, 16'h0100, 1'b1},
      '{'{OP_WRITE, REG_CMD, {EFF_FULL, 4'd6, 2'd2}, 2'd3, 8'h00},
        1'b1, 10'd0, 16'h0200, 1'b1},
      '{'{OP_WRITE, REG_READY,   8'h00, 2'd0, 8'h00}, 1'b1, 10'd0, 16'h0000, 1'b1},
      // most negative byte at full level and volume: -128 * 4
      '{'{OP_TICK,  REG_CMD,     8'h00, 2'd0, 8'h80}, 1'b1, 10'h200, 16'h0001, 1'b1},
      '{'{OP_TICK,  REG_CMD,     8'h00, 2'd0, 8'h7F}, 1'b1, 10'd508, 16'h0002, 1'b1},
      // position reaches next slot start minus one: stops
      '{'{OP_TICK,  REG_CMD,     8'h00, 2'd0, 8'h00}, 1'b1, 10'd0, 16'h0003, 1'b0},
      // idle channel gives silence
      '{'{OP_TICK,  REG_CMD,     8'h00, 2'd0, 8'hFF}, 1'b1, 10'd0, 16'h0003, 1'b0},
      // seven-tenths, position wraps past 0xffff
      '{'{OP_TICK,  REG_CMD,     8'h00, 2'd1, 8'h7F}, 1'b0, 10'd0, 16'h0000, 1'b0},
      '{'{OP_TICK,  REG_CMD,     8'h00, 2'd1, 8'h81}, 1'b0, 10'd0, 16'h0000, 1'b0},
      '{'{OP_TICK,  REG_CMD,     8'h00, 2'd1, 8'h80}, 1'b0, 10'd0, 16'h0000, 1'b0},
      // two-fifths, end address from a zero next-slot start
      '{'{OP_TICK,  REG_CMD,     8'h00, 2'd2, 8'h80}, 1'b0, 10'd0, 16'h0000, 1'b0},
      '{'{OP_TICK,  REG_CMD,     8'h00, 2'd2, 8'h7F}, 1'b0, 10'd0, 16'h0000, 1'b0},
      // start past the end
      '{'{OP_TICK,  REG_CMD,     8'h00, 2'd3, 8'h01}, 1'b0, 10'd0, 16'h0000, 1'b0},
      // play command on a high slot only moves the selection
      '{'{OP_WRITE, REG_CMD, {EFF_FULL, 4'd9, 2'd1}, 2'd3, 8'h00},
        1'b0, 10'd0, 16'h0000, 1'b0},
      // rewrite slot 3 to 0xffff through the address registers
      '{'{OP_WRITE, REG_CMD, {CMD_STORE, 4'd3, 2'd0}, 2'd2, 8'h00},
        1'b0, 10'd0, 16'h0000, 1'b0},
      '{'{OP_WRITE, REG_ADDR_LO, 8'hFF, 2'd1, 8'h00}, 1'b0, 10'd0, 16'h0000, 1'b0},
      '{'{OP_WRITE, REG_ADDR_HI, 8'hFF, 2'd1, 8'h00}, 1'b0, 10'd0, 16'h0000, 1'b0},
      '{'{OP_WRITE, REG_CMD, {EFF_SEVEN, 4'd2, 2'd3}, 2'd1, 8'h00},
        1'b0, 10'd0, 16'h0000, 1'b0},
      '{'{OP_TICK,  REG_CMD,     8'h00, 2'd1, 8'h55}, 1'b0, 10'd0, 16'h0000, 1'b0},
      // odd slot lands on the same channel as its even partner
      '{'{OP_WRITE, REG_CMD, {EFF_TWO, 4'd1, 2'd2}, 2'd0, 8'h00},
        1'b0, 10'd0, 16'h0000, 1'b0},
      '{'{OP_TICK,  REG_CMD,     8'h00, 2'd0, 8'hAA}, 1'b0, 10'd0, 16'h0000, 1'b0}
   };

   // ------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_samples.size() == 0) begin
            $error("result with nothing pending: sample_value %0d fetch_address %h",
                   rsp_if.sample_value, rsp_if.fetch_address);
            mismatch_count++;
         end else begin
            exp_res = expected_samples.pop_front();
            results_checked++;
            if (rsp_if.sample_value !== exp_res.sample_value) begin
               $error("sample_value: expected %0d, got %0d",
                      exp_res.sample_value, rsp_if.sample_value);
               mismatch_count++;
            end
            // position of a never started channel is not defined
            if (exp_res.addr_known && rsp_if.fetch_address !== exp_res.fetch_address) begin
               $error("fetch_address: expected %h, got %h",
                      exp_res.fetch_address, rsp_if.fetch_address);
               mismatch_count++;
            end
            if (rsp_if.channel_active !== exp_res.channel_active) begin
               $error("channel_active: expected %0b, got %0b",
                      exp_res.channel_active, rsp_if.channel_active);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // watchdog: no handshake on either side for too long
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d results still pending", expected_samples.size());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // result side back-pressure, cycling through four modes
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      case ((rx_cycle / 256) % 4)
         0:       rsp_if.ready <= 1'b1;
         1:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
         2:       rsp_if.ready <= ((rx_cycle % 7) < 4);
         default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      int              kind;
      logic [3:0]      slot;
      logic [15:0]     start_val;
      drum_result_type typed_res;

      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.operation  = OP_WRITE;
      req_if.reg_offset = REG_CMD;
      req_if.write_data = 8'h00;
      req_if.channel    = 2'd0;
      req_if.rom_data   = 8'h00;
      rsp_if.ready      = 1'b0;
      rx_cycle          = 0;
      idle_cycles       = 0;
      burst_left        = 0;
      items_sent        = 0;
      ticks_sent        = 0;
      results_checked   = 0;
      channel_stops     = 0;
      mismatch_count    = 0;

      // model reset: entries that are undefined in hardware start at zero here
      for (int i = 0; i < ADDR_SLOTS; i++) slot_start[i] = 16'h0000;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         chan_pos[i]       = 16'h0000;
         chan_pos_known[i] = 1'b0;
         chan_playing[i]   = 1'b0;
         chan_slot[i]      = 3'd0;
         chan_vol[i]       = 2'd0;
         chan_eff[i]       = EFF_MUTE;
      end
      sel_slot     = 4'd0;
      player_ready = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // load every slot start that playback can read: select, low byte, high byte
      for (int i = 0; i < SETUP_SLOTS; i++) begin
         send_write(REG_CMD, {CMD_STORE, 4'(i), 2'd0}, 2'd0);
         send_write(REG_ADDR_LO, INIT_SLOT_START[i][7:0], 2'd0);
         send_write(REG_ADDR_HI, INIT_SLOT_START[i][15:8], 2'd0);
      end

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         typed_res.sample_value   = directed_rows[r].sample_value;
         typed_res.fetch_address  = directed_rows[r].fetch_address;
         typed_res.channel_active = directed_rows[r].channel_active;
         typed_res.addr_known     = 1'b1;
         send_item(directed_rows[r].item, directed_rows[r].typed, typed_res);
      end

      // random part: mostly ticks and play commands, address reprogramming as
      // complete select/low/high sequences, some ready writes, the rest is noise
      while (items_sent < ITEM_TARGET) begin
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            send_tick(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end else if (kind < 70) begin
            slot = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                               : 4'($urandom_range(0, 7));
            send_write(REG_CMD, {2'($urandom_range(1, 3)), slot, 2'($urandom_range(0, 3))},
                       2'($urandom_range(0, 3)));
         end else if (kind < 82) begin
            slot      = 4'($urandom_range(0, 15));
            start_val = pick_slot_start(slot);
            send_write(REG_CMD, {CMD_STORE, slot, 2'($urandom_range(0, 3))},
                       2'($urandom_range(0, 3)));
            send_write(REG_ADDR_LO, start_val[7:0], 2'($urandom_range(0, 3)));
            send_write(REG_ADDR_HI, start_val[15:8], 2'($urandom_range(0, 3)));
         end else if (kind < 87) begin
            send_write(REG_READY, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
         end else begin
            send_item('{1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                        8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                        8'($urandom_range(0, 255))}, 1'b0, '0);
         end
      end
      req_if.valid = 1'b0;

      // drain, watchdog guards against a hang
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_samples.size() != 0) begin
         $error("%0d expected results never arrived", expected_samples.size());
         mismatch_count++;
      end

      $display("stimulus: %0d items, %0d of them ticks, %0d playback ends reached",
               items_sent, ticks_sent, channel_stops);
      $display("checker: %0d results compared, %0d field errors",
               results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: percussion_sample_player.f
rtl/pspl_pkg.sv
rtl/pspl_if.sv
rtl/pspl_ram.sv
rtl/pspl_mac.sv
rtl/percussion_sample_player.sv
dv/tb_top.sv
